// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl of the shaper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising clk outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/prcs_pkg.sv =====
// types and constants of the peak rate cell shaper
`default_nettype none

package prcs_pkg;

    localparam int DELTA_W  = 16;
    localparam int SPLASH_W = 17;
    localparam int QLIM_W   = 7;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // 1.0 in q1.16
    localparam logic [SPLASH_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELTA_SHORT = 2'd0,
        CFG_SPLASH      = 2'd1,
        CFG_QUEUE_LIMIT = 2'd2
    } cfg_index_t;

    // slot decision carried from the decision stage to the result register
    typedef struct packed {
        logic              out_valid;
        logic              from_ram;
        logic              dropped;
        logic [QLIM_W-1:0] queue_length;
        logic [CNT_W-1:0]  drop_count;
        logic              count_wrapped;
    } slot_res_t;

endpackage

`default_nettype wire

// ===== sv/prcs_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module prcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/peak_rate_cell_shaper.sv =====
// peak rate cell shaper: spaces cell departures with a fractional interval
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: cell_data; tuser: cell_valid
//  m_axis   | out | m_axis_tvalid/tready   | tdata: out_data, dropped, queue_length,
//           |     |                        |        drop_count, count_wrapped; tuser: out_valid
//  cfg      | in  | cfg_wr_en              | cfg_index, cfg_data
//
// one slot item is taken every clock while s_axis_tready is high; its result passes through the decision stage
// and the result register, with buffered cells taken from the registered read of the cell buffer ram
// spacing state is updated at the edge the item is taken, so slots follow back to back
// reset clears control state only; the buffer ram needs no clearing pass
// m_axis_tready low holds the result; s_axis_tready falls only when both stages are full
`default_nettype none

`include "assert_macros.svh"

module peak_rate_cell_shaper
    import prcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int CELL_WIDTH  = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // cell_data
    input  logic [((CELL_WIDTH + 7) / 8) * 8 - 1:0]    s_axis_tdata,
    // cell_valid
    input  logic [0:0]                                s_axis_tuser,

    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // out_data, dropped, queue_length, drop_count, count_wrapped
    output logic [((CELL_WIDTH + 41 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // out_valid
    output logic [0:0]                                m_axis_tuser,

    input  logic                                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                      cfg_index,
    input  logic [CFG_W-1:0]                          cfg_data
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W   = (FILL_W > QLIM_W) ? FILL_W : QLIM_W;
    localparam int OUT_BITS = CELL_WIDTH + 1 + QLIM_W + CNT_W + 1;
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(QUEUE_DEPTH);

    // configuration
    logic [DELTA_W-1:0]  delta_short_reg;
    logic [SPLASH_W-1:0] splash_reg;
    logic [QLIM_W-1:0]   queue_limit_reg;

    // spacing and buffer state
    logic [PTR_W-1:0]    head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]    tail_ptr_reg, tail_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [DELTA_W-1:0]  gap_reg, gap_next;
    logic                late_reg, late_next;
    logic [15:0]         accum_reg, accum_next;
    logic [CNT_W-1:0]    drop_cnt_reg, drop_cnt_next;

    // decision stage and result register
    logic                a_valid_reg;
    slot_res_t           a_res_reg, a_res_next;
    logic [CELL_WIDTH-1:0] a_data_reg;
    logic                b_valid_reg;
    slot_res_t           b_res_reg;
    logic [CELL_WIDTH-1:0] b_data_reg;

    logic                in_acc;
    logic                a_move;
    logic                arrive;
    logic [CELL_WIDTH-1:0] cell_data;
    logic                fifo_dep;
    logic                direct;
    logic                enq;
    logic                drop;
    logic                departed;
    logic [FILL_W-1:0]   fill_after;
    logic [LIM_W-1:0]    limit;
    logic [LIM_W-1:0]    fill_cmp;
    logic [LIM_W-1:0]    fill_next_ext;
    logic [DELTA_W-1:0]  delta_eff;
    logic [SPLASH_W-1:0] splash_eff;
    logic [15:0]         accum_base;
    logic [SPLASH_W-1:0] frac_sum;
    logic [CELL_WIDTH-1:0] ram_rdata;
    logic [CELL_WIDTH-1:0] res_data;

    assign arrive    = s_axis_tuser[0];
    assign cell_data = s_axis_tdata[CELL_WIDTH-1:0];

    assign a_move        = a_valid_reg && (!b_valid_reg || m_axis_tready);
    assign s_axis_tready = !a_valid_reg || a_move;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_short_reg <= DELTA_W'(1);
            splash_reg      <= ONE_Q16;
            queue_limit_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DELTA_SHORT: delta_short_reg <= cfg_data[DELTA_W-1:0];
                CFG_SPLASH:      splash_reg      <= cfg_data[SPLASH_W-1:0];
                CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_data[QLIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // slot decision
    always_comb
    begin
        limit = (LIM_W'(queue_limit_reg) > DEPTH_LIM) ? DEPTH_LIM : LIM_W'(queue_limit_reg);

        fifo_dep   = (fill_reg != '0) && (gap_reg == '0);
        fill_after = fill_reg - FILL_W'(fifo_dep);
        fill_cmp   = LIM_W'(fill_after);
        direct     = arrive && !fifo_dep && (fill_reg == '0) && (gap_reg == '0);
        enq        = arrive && !direct && (fill_cmp < limit);
        drop       = arrive && !direct && !enq;
        departed   = fifo_dep || direct;
        fill_next  = fill_after + FILL_W'(enq);

        // the accumulator restarts after a real pause
        delta_eff  = (delta_short_reg == '0) ? DELTA_W'(1) : delta_short_reg;
        splash_eff = (splash_reg > ONE_Q16) ? ONE_Q16 : splash_reg;
        accum_base = (direct && late_reg) ? 16'd0 : accum_reg;
        frac_sum   = SPLASH_W'(accum_base) + splash_eff;

        // a carry picks the short interval; gap is interval minus one
        accum_next = departed ? frac_sum[15:0] : accum_reg;
        if (departed)
        begin
            gap_next  = frac_sum[16] ? (delta_eff - DELTA_W'(1)) : delta_eff;
            late_next = 1'b0;
        end
        else if (gap_reg != '0)
        begin
            gap_next  = gap_reg - DELTA_W'(1);
            late_next = late_reg;
        end
        else
        begin
            gap_next  = gap_reg;
            late_next = 1'b1;
        end

        head_ptr_next = fifo_dep ? ((head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + PTR_W'(1))
                                 : head_ptr_reg;
        tail_ptr_next = enq ? ((tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + PTR_W'(1))
                            : tail_ptr_reg;
        drop_cnt_next = drop_cnt_reg + CNT_W'(drop);

        fill_next_ext = LIM_W'(fill_next);

        a_res_next.out_valid     = departed;
        a_res_next.from_ram      = fifo_dep;
        a_res_next.dropped       = drop;
        a_res_next.queue_length  = fill_next_ext[QLIM_W-1:0];
        a_res_next.drop_count    = drop_cnt_next;
        a_res_next.count_wrapped = drop && (drop_cnt_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            fill_reg     <= '0;
            gap_reg      <= '0;
            late_reg     <= 1'b0;
            accum_reg    <= '0;
            drop_cnt_reg <= '0;
        end
        else if (in_acc)
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            fill_reg     <= fill_next;
            gap_reg      <= gap_next;
            late_reg     <= late_next;
            accum_reg    <= accum_next;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

    // head cell read is issued at the edge the slot is taken; rdata holds while stalled
    prcs_ram #(
        .WIDTH (CELL_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (in_acc && enq),
        .waddr (tail_ptr_reg),
        .wdata (cell_data),
        .re    (in_acc && fifo_dep),
        .raddr (head_ptr_reg),
        .rdata (ram_rdata)
    );

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        priority if (a_res_reg.from_ram)
        begin
            res_data = ram_rdata;
        end
        else if (a_res_reg.out_valid)
        begin
            res_data = a_data_reg;
        end
        else
        begin
            res_data = '0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_res_reg  <= a_res_next;
            a_data_reg <= cell_data;
        end
        if (a_move)
        begin
            b_res_reg  <= a_res_reg;
            b_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid   = b_valid_reg;
    assign m_axis_tuser[0] = b_res_reg.out_valid;
    assign m_axis_tdata    = OUT_W'({b_res_reg.count_wrapped, b_res_reg.drop_count,
                                     b_res_reg.queue_length, b_res_reg.dropped, b_data_reg});

    `ASSERT_NEXT(a_ram_hold, a_valid_reg && !a_move, $stable(ram_rdata), "head cell read data changed while the decision stage stalled")
    `ASSERT_NEXT(a_dep_tracks, in_acc && fifo_dep, a_valid_reg && a_res_reg.from_ram && a_res_reg.out_valid, "buffered departure lost on its way to the result stage")
    `ASSERT_IMPL(a_gap_blocks, in_acc && (gap_reg != '0), !departed, "cell departed before the spacing gap expired")
    `ASSERT_IMPL(a_ptr_empty, fill_reg == '0, head_ptr_reg == tail_ptr_reg, "buffer pointers differ while the buffer is empty")

endmodule

`default_nettype wire
